// ===== rtl/jsas_pkg.sv =====
// Shared types, codes and defaults for the job slot admission scheduler.
`default_nettype none
package jsas_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int MAX_SLOTS_DEF     = 5;

   localparam logic [2:0] CONC_FLOOR = 3'd1;
   localparam logic [2:0] CONC_CEIL  = 3'd5;
   localparam logic [2:0] CONC_RESET = 3'd3;

   localparam logic [0:0] CSR_MAX_CONC = 1'd0;
   localparam logic [0:0] CSR_AUTO_ACT = 1'd1;

   localparam logic [3:0] ACT_ADD       = 4'd0;
   localparam logic [3:0] ACT_PAUSE     = 4'd1;
   localparam logic [3:0] ACT_RESUME    = 4'd2;
   localparam logic [3:0] ACT_RETRY     = 4'd3;
   localparam logic [3:0] ACT_REMOVE    = 4'd4;
   localparam logic [3:0] ACT_FINISHED  = 4'd5;
   localparam logic [3:0] ACT_ERROR     = 4'd6;
   localparam logic [3:0] ACT_CANCELLED = 4'd7;
   localparam logic [3:0] ACT_TICK      = 4'd8;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_PAUSED  = 3'd1;
   localparam logic [2:0] PH_RUNNING = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_FAILED  = 3'd4;

   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NF    = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_ADMIT  = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   typedef struct packed {
      logic [3:0]  action;
      logic [15:0] job_id;
      logic        start_paused;
      logic [47:0] start_at;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] job_ref;
      logic [2:0]  job_state;
      logic [1:0]  status;
      logic [1:0]  fired_action;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ident;
      logic [2:0]  phase;
      logic [47:0] start_time;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic do_ack;
      logic do_cancel;
      logic do_start;
      logic do_finish;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic       emit_ok;
      logic       out_free;
      logic       need_cancel;
      logic [1:0] mode;
      logic       adm_go;
      logic       finish_go;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== rtl/jsas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/jsas_dp.sv =====
// Datapath: job table, scan accumulators, action decode and result buffering.
`default_nettype none
module jsas_dp #(
   parameter int TABLE_ENTRIES = jsas_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_SLOTS     = jsas_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire jsas_pkg::dp_cmd_type cmd,
   output jsas_pkg::dp_sts_type      sts,
   input  wire jsas_pkg::req_type    req_data,
   output jsas_pkg::rsp_type         rsp_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic                 csr_we,
   input  wire logic [0:0]           csr_addr,
   input  wire logic [2:0]           csr_wdata
);

   localparam int IW   = $clog2(TABLE_ENTRIES);
   localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
   localparam int CMPW = (CNTW > 5) ? CNTW : 5;
   localparam int EW   = $bits(jsas_pkg::entry_type);

   // configuration
   logic [2:0] max_conc_ff, max_conc_in;
   logic [1:0] auto_act_ff, auto_act_in;

   // block state
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [15:0]              next_id_ff, next_id_in;
   logic                     fin_rep_ff, fin_rep_in;
   logic                     auto_fired_ff, auto_fired_in;

   jsas_pkg::req_type req_ff, req_in;

   // scan sequencing
   logic          scan_act_ff, scan_act_in;
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic          dvld_ff, dvld_in;
   logic [IW-1:0] didx_ff, didx_in;
   logic          done_ff, done_in;

   // scan accumulators
   logic                free_fnd_ff, free_fnd_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic                hit_fnd_ff, hit_fnd_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   jsas_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic                best_fnd_ff, best_fnd_in;
   logic [IW-1:0]       best_idx_ff, best_idx_in;
   jsas_pkg::entry_type best_ent_ff, best_ent_in;
   logic [CNTW-1:0]     run_cnt_ff, run_cnt_in;
   logic                active_ff, active_in;

   // result buffering
   jsas_pkg::rsp_type pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   jsas_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_vld_ff, rsp_vld_in;

   jsas_pkg::entry_type rd_ent;
   logic [EW-1:0]       rd_raw;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   jsas_pkg::entry_type wr_ent;

   // action decode
   logic [15:0] a_ref;
   logic [2:0]  a_state;
   logic [1:0]  a_status;
   logic [1:0]  a_mode;
   logic        a_cancel;
   logic        a_hitw;
   logic [2:0]  a_newph;
   logic        a_add;
   logic        a_clrv;
   logic        a_clrfin;
   logic [2:0]  need_ph;

   logic [4:0]      lim;
   logic            out_free;
   logic            eligible;
   logic            dv;
   logic [1:0]      fired;
   jsas_pkg::rsp_type res_new;
   logic            emit;

   jsas_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_raw)
   );

   assign rd_ent   = rd_raw;
   assign lim      = ({2'b00, max_conc_ff} > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS)
                                                           : {2'b00, max_conc_ff};
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign dv       = dvld_ff && valid_ff[didx_ff];
   assign eligible = dv && (rd_ent.phase == jsas_pkg::PH_IDLE)
                     && ((rd_ent.start_time == 48'd0) || (rd_ent.start_time <= req_ff.now_ms));
   assign fired    = (auto_act_ff != 2'd0 && !auto_fired_ff) ? auto_act_ff : 2'd0;
   assign need_ph  = (req_ff.action == jsas_pkg::ACT_RESUME) ? jsas_pkg::PH_PAUSED
                                                             : jsas_pkg::PH_FAILED;

   always_comb begin
      a_ref    = req_ff.job_id;
      a_state  = hit_ent_ff.phase;
      a_status = jsas_pkg::STAT_OK;
      a_mode   = jsas_pkg::MODE_NONE;
      a_cancel = 1'b0;
      a_hitw   = 1'b0;
      a_newph  = hit_ent_ff.phase;
      a_add    = 1'b0;
      a_clrv   = 1'b0;
      a_clrfin = 1'b0;
      case (req_ff.action)
         jsas_pkg::ACT_ADD: begin
            if (free_fnd_ff) begin
               a_ref   = next_id_ff;
               a_state = req_ff.start_paused ? jsas_pkg::PH_PAUSED : jsas_pkg::PH_IDLE;
               a_add   = 1'b1;
               a_mode  = req_ff.start_paused ? jsas_pkg::MODE_NONE : jsas_pkg::MODE_ADMIT;
            end else begin
               a_ref    = 16'd0;
               a_state  = jsas_pkg::PH_IDLE;
               a_status = jsas_pkg::STAT_FULL;
            end
         end
         jsas_pkg::ACT_TICK: begin
            a_ref   = 16'd0;
            a_state = jsas_pkg::PH_IDLE;
            a_mode  = jsas_pkg::MODE_ADMIT;
         end
         jsas_pkg::ACT_REMOVE: begin
            a_mode = jsas_pkg::MODE_ADMIT;
            if (hit_fnd_ff) begin
               a_cancel = (hit_ent_ff.phase == jsas_pkg::PH_RUNNING);
               a_clrv   = 1'b1;
            end else begin
               a_state  = jsas_pkg::PH_IDLE;
               a_status = jsas_pkg::STAT_NF;
            end
         end
         jsas_pkg::ACT_PAUSE, jsas_pkg::ACT_RESUME, jsas_pkg::ACT_RETRY,
         jsas_pkg::ACT_FINISHED, jsas_pkg::ACT_ERROR, jsas_pkg::ACT_CANCELLED: begin
            if (!hit_fnd_ff) begin
               a_state  = jsas_pkg::PH_IDLE;
               a_status = jsas_pkg::STAT_NF;
            end else if (req_ff.action == jsas_pkg::ACT_PAUSE) begin
               if (hit_ent_ff.phase == jsas_pkg::PH_RUNNING) begin
                  a_cancel = 1'b1;
               end else if (hit_ent_ff.phase == jsas_pkg::PH_IDLE) begin
                  a_hitw  = 1'b1;
                  a_newph = jsas_pkg::PH_PAUSED;
                  a_state = jsas_pkg::PH_PAUSED;
                  a_mode  = jsas_pkg::MODE_FINISH;
               end else begin
                  a_status = jsas_pkg::STAT_NF;
               end
            end else if (req_ff.action == jsas_pkg::ACT_RESUME
                         || req_ff.action == jsas_pkg::ACT_RETRY) begin
               if (hit_ent_ff.phase == need_ph) begin
                  a_hitw   = 1'b1;
                  a_newph  = jsas_pkg::PH_IDLE;
                  a_state  = jsas_pkg::PH_IDLE;
                  a_clrfin = 1'b1;
                  a_mode   = jsas_pkg::MODE_ADMIT;
               end else begin
                  a_status = jsas_pkg::STAT_NF;
               end
            end else if (req_ff.action == jsas_pkg::ACT_CANCELLED) begin
               a_mode = jsas_pkg::MODE_ADMIT;
               if (hit_ent_ff.phase == jsas_pkg::PH_RUNNING) begin
                  a_hitw  = 1'b1;
                  a_newph = jsas_pkg::PH_PAUSED;
                  a_state = jsas_pkg::PH_PAUSED;
               end else begin
                  a_status = jsas_pkg::STAT_NF;
               end
            end else begin
               a_hitw  = 1'b1;
               a_newph = (req_ff.action == jsas_pkg::ACT_FINISHED) ? jsas_pkg::PH_DONE
                                                                 : jsas_pkg::PH_FAILED;
               a_state = a_newph;
               a_mode  = jsas_pkg::MODE_ADMIT;
            end
         end
         default: begin
            a_ref    = 16'd0;
            a_state  = jsas_pkg::PH_IDLE;
            a_status = jsas_pkg::STAT_NF;
         end
      endcase
   end

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_ent  = hit_ent_ff;
      if (cmd.do_start) begin
         wr_en        = 1'b1;
         wr_addr      = best_idx_ff;
         wr_ent       = best_ent_ff;
         wr_ent.phase = jsas_pkg::PH_RUNNING;
      end else if (cmd.do_ack && a_add) begin
         wr_en            = 1'b1;
         wr_addr          = free_idx_ff;
         wr_ent.ident     = next_id_ff;
         wr_ent.phase     = a_state;
         wr_ent.start_time = req_ff.start_at;
      end else if (cmd.do_ack && a_hitw) begin
         wr_en        = 1'b1;
         wr_ent.phase = a_newph;
      end
   end

   // result to emit this cycle
   always_comb begin
      emit    = cmd.do_ack || cmd.do_cancel || cmd.do_start || cmd.do_finish;
      res_new = '0;
      if (cmd.do_ack) begin
         res_new.kind      = jsas_pkg::KIND_ACK;
         res_new.job_ref   = a_ref;
         res_new.job_state = a_state;
         res_new.status    = a_status;
      end else if (cmd.do_cancel) begin
         res_new.kind      = jsas_pkg::KIND_CANCEL;
         res_new.job_ref   = req_ff.job_id;
         res_new.job_state = jsas_pkg::PH_RUNNING;
      end else if (cmd.do_start) begin
         res_new.kind      = jsas_pkg::KIND_START;
         res_new.job_ref   = best_ent_ff.ident;
         res_new.job_state = jsas_pkg::PH_RUNNING;
      end else if (cmd.do_finish) begin
         res_new.kind         = jsas_pkg::KIND_FINISH;
         res_new.fired_action = fired;
      end
   end

   always_comb begin
      max_conc_in   = max_conc_ff;
      auto_act_in   = auto_act_ff;
      valid_in      = valid_ff;
      next_id_in    = next_id_ff;
      fin_rep_in    = fin_rep_ff;
      auto_fired_in = auto_fired_ff;
      req_in        = req_ff;
      scan_act_in   = scan_act_ff;
      scan_idx_in   = scan_idx_ff;
      dvld_in       = scan_act_ff;
      didx_in       = scan_idx_ff;
      done_in       = done_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      hit_fnd_in    = hit_fnd_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      best_fnd_in   = best_fnd_ff;
      best_idx_in   = best_idx_ff;
      best_ent_in   = best_ent_ff;
      run_cnt_in    = run_cnt_ff;
      active_in     = active_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_in        = rsp_ff;
      rsp_vld_in    = rsp_vld_ff;

      if (csr_we) begin
         case (csr_addr)
            jsas_pkg::CSR_MAX_CONC: begin
               if (csr_wdata < jsas_pkg::CONC_FLOOR) begin
                  max_conc_in = jsas_pkg::CONC_FLOOR;
               end else if (csr_wdata > jsas_pkg::CONC_CEIL) begin
                  max_conc_in = jsas_pkg::CONC_CEIL;
               end else begin
                  max_conc_in = csr_wdata;
               end
            end
            jsas_pkg::CSR_AUTO_ACT: auto_act_in = csr_wdata[1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         req_in = req_data;
      end

      // one entry a cycle; read data is registered in the RAM, so didx holds the index of the entry being read out
      if (scan_act_ff) begin
         if (scan_idx_ff == IW'(TABLE_ENTRIES - 1)) begin
            scan_act_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + IW'(1);
         end
      end
      if (dvld_ff) begin
         if (!valid_ff[didx_ff] && !free_fnd_ff) begin
            free_fnd_in = 1'b1;
            free_idx_in = didx_ff;
         end
         if (dv && rd_ent.ident == req_ff.job_id && !hit_fnd_ff) begin
            hit_fnd_in = 1'b1;
            hit_idx_in = didx_ff;
            hit_ent_in = rd_ent;
         end
         if (dv && rd_ent.phase == jsas_pkg::PH_RUNNING) begin
            run_cnt_in = run_cnt_ff + CNTW'(1);
         end
         if (dv && rd_ent.phase <= jsas_pkg::PH_RUNNING) begin
            active_in = 1'b1;
         end
         if (eligible && (!best_fnd_ff || rd_ent.ident < best_ent_ff.ident)) begin
            best_fnd_in = 1'b1;
            best_idx_in = didx_ff;
            best_ent_in = rd_ent;
         end
         if (didx_ff == IW'(TABLE_ENTRIES - 1)) begin
            done_in = 1'b1;
         end
      end
      if (cmd.scan_start) begin
         scan_act_in = 1'b1;
         scan_idx_in = '0;
         dvld_in     = 1'b0;
         done_in     = 1'b0;
         free_fnd_in = 1'b0;
         hit_fnd_in  = 1'b0;
         best_fnd_in = 1'b0;
         run_cnt_in  = '0;
         active_in   = 1'b0;
      end

      if (cmd.do_ack) begin
         if (a_add) begin
            valid_in[free_idx_ff] = 1'b1;
            next_id_in            = next_id_ff + 16'd1;
            fin_rep_in            = 1'b0;
            auto_fired_in         = 1'b0;
         end
         if (a_clrv) begin
            valid_in[hit_idx_ff] = 1'b0;
         end
         if (a_clrfin) begin
            fin_rep_in = 1'b0;
         end
      end
      if (cmd.do_finish) begin
         fin_rep_in = 1'b1;
         if (fired != 2'd0) begin
            auto_fired_in = 1'b1;
         end
      end

      // two-deep result path: pending holds the newest until its last flag is known
      if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
      if (emit) begin
         if (pend_vld_ff) begin
            rsp_in     = pend_ff;
            rsp_vld_in = 1'b1;
         end
         pend_in     = res_new;
         pend_vld_in = 1'b1;
      end else if (cmd.flush) begin
         rsp_in      = pend_ff;
         rsp_in.last = 1'b1;
         rsp_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_conc_ff   <= jsas_pkg::CONC_RESET;
         auto_act_ff   <= 2'd0;
         valid_ff      <= '0;
         next_id_ff    <= 16'd0;
         fin_rep_ff    <= 1'b0;
         auto_fired_ff <= 1'b0;
         scan_act_ff   <= 1'b0;
         dvld_ff       <= 1'b0;
         done_ff       <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         max_conc_ff   <= max_conc_in;
         auto_act_ff   <= auto_act_in;
         valid_ff      <= valid_in;
         next_id_ff    <= next_id_in;
         fin_rep_ff    <= fin_rep_in;
         auto_fired_ff <= auto_fired_in;
         scan_act_ff   <= scan_act_in;
         dvld_ff       <= dvld_in;
         done_ff       <= done_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      didx_ff     <= didx_in;
      free_fnd_ff <= free_fnd_in;
      free_idx_ff <= free_idx_in;
      hit_fnd_ff  <= hit_fnd_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      best_fnd_ff <= best_fnd_in;
      best_idx_ff <= best_idx_in;
      best_ent_ff <= best_ent_in;
      run_cnt_ff  <= run_cnt_in;
      active_ff   <= active_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.scan_done   = done_ff;
   assign sts.emit_ok     = !pend_vld_ff || out_free;
   assign sts.out_free    = out_free;
   assign sts.need_cancel = a_cancel;
   assign sts.mode        = a_mode;
   assign sts.adm_go      = best_fnd_ff && (CMPW'(run_cnt_ff) < CMPW'(lim));
   assign sts.finish_go   = !fin_rep_ff && !active_ff;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_vld_ff;

endmodule
`default_nettype wire

// ===== rtl/jsas_ctrl.sv =====
// Controller: sequences scan passes, action, admissions and finish check.
`default_nettype none
module jsas_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire jsas_pkg::dp_sts_type sts,
   output jsas_pkg::dp_cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN0  = 4'd1;
   localparam logic [3:0] ST_ACK    = 4'd2;
   localparam logic [3:0] ST_CANCEL = 4'd3;
   localparam logic [3:0] ST_RESCAN = 4'd4;
   localparam logic [3:0] ST_SCAN   = 4'd5;
   localparam logic [3:0] ST_DECIDE = 4'd6;
   localparam logic [3:0] ST_START  = 4'd7;
   localparam logic [3:0] ST_FIN    = 4'd8;
   localparam logic [3:0] ST_FLUSH  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [3:0] after_act;

   assign after_act = (mode_ff == jsas_pkg::MODE_NONE) ? ST_FLUSH : ST_RESCAN;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN0;
            end
         end
         ST_SCAN0: begin
            if (sts.scan_done) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (sts.emit_ok) begin
               cmd.do_ack = 1'b1;
               mode_in    = sts.mode;
               if (sts.need_cancel) begin
                  state_in = ST_CANCEL;
               end else if (sts.mode == jsas_pkg::MODE_NONE) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_RESCAN;
               end
            end
         end
         ST_CANCEL: begin
            if (sts.emit_ok) begin
               cmd.do_cancel = 1'b1;
               state_in      = after_act;
            end
         end
         ST_RESCAN: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (mode_ff == jsas_pkg::MODE_ADMIT && sts.adm_go) begin
               state_in = ST_START;
            end else if (sts.finish_go) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_START: begin
            if (sts.emit_ok) begin
               cmd.do_start = 1'b1;
               state_in     = ST_RESCAN;
            end
         end
         ST_FIN: begin
            if (sts.emit_ok) begin
               cmd.do_finish = 1'b1;
               state_in      = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= jsas_pkg::MODE_NONE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/job_slot_admission_scheduler_top.sv =====
// Top level of the job slot admission scheduler.
// Usage:
//  - Request channel (req_valid / req_stall / req_data): one action per request.
//    A request is taken when req_valid is high and req_stall low.
//  - Result channel (rsp_valid / rsp_stall / rsp_data): an acknowledge, then an
//    optional cancel, start results, then an optional queue-finished record;
//    rsp_data.last marks the final record of a request.
//  - csr_we / csr_addr / csr_wdata: register 0 max_concurrent (clamped 1..5),
//    register 1 auto_action. Write only while no request is in flight.
// Timing: every pass over the job table reads one entry a cycle from the
//  table RAM. A request costs the lookup pass and an acknowledge step, a
//  cancel step if a running job is paused or removed, one more pass plus a
//  decide step if it admits or checks for finish, and another pass, decide
//  and start step per admitted job, a finish step if a queue-finished record
//  is sent, plus a flush step. One request at a time.
// Reset (synchronous, active high) empties the table, zeroes the id counter,
//  the finish and auto-fire flags, and loads max_concurrent 3, auto_action 0.
// A stalled result holds in the output register; one more result can wait in
//  a pending stage, after which the sequencer waits for the receiver.
`default_nettype none
module job_slot_admission_scheduler_top #(
   parameter int TABLE_ENTRIES = jsas_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_SLOTS     = jsas_pkg::MAX_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire jsas_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output jsas_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_addr,
   input  wire logic [2:0]        csr_wdata
);

   jsas_pkg::dp_cmd_type cmd;
   jsas_pkg::dp_sts_type sts;

   // sequencer: lookup pass, action, admission loop, finish check
   jsas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, scan accumulators and result buffering
   jsas_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_SLOTS     (MAX_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

// ===== sim/job_slot_admission_scheduler_top_test.sv =====
// Self-checking testbench for the job slot admission scheduler top level.
`timescale 1ns / 100ps
`default_nettype none
module job_slot_admission_scheduler_top_test;

   localparam int SLOTS = jsas_pkg::TABLE_ENTRIES_DEF;
   localparam int CAP   = jsas_pkg::MAX_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   jsas_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   jsas_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [0:0] csr_addr = '0;
   logic [2:0] csr_wdata = '0;

   always #6 clock = ~clock;

   job_slot_admission_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Shadow job table, kept in step with every accepted request
   logic        sh_valid [SLOTS];
   logic [15:0] sh_ident [SLOTS];
   logic [2:0]  sh_phase [SLOTS];
   logic [47:0] sh_start [SLOTS];
   logic [15:0] sh_next_id;
   logic        sh_fin_reported;
   logic        sh_auto_fired;
   logic [2:0]  sh_limit;
   logic [1:0]  sh_auto_act;

   jsas_pkg::rsp_type expected_rsps[$];
   int      fail_count = 0;
   longint  cycle_count = 0;
   logic    rsp_stall_rand = 1'b0;  // receiver stalls only when set

   task automatic push_rsp(input logic [1:0] kind, input logic [15:0] ref_id,
                           input logic [2:0] st, input logic [1:0] stat,
                           input logic [1:0] fired);
      jsas_pkg::rsp_type r;
      r.kind = kind; r.job_ref = ref_id; r.job_state = st;
      r.status = stat; r.fired_action = fired; r.last = 1'b0;
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   function automatic int lookup_slot(input logic [15:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && sh_ident[i] == id) return i;
      return -1;
   endfunction

   task automatic finish_check();
      logic [1:0] fired;
      fired = 2'd0;
      if (sh_fin_reported) return;
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && sh_phase[i] <= jsas_pkg::PH_RUNNING) return;
      sh_fin_reported = 1'b1;
      if (sh_auto_act != 2'd0 && !sh_auto_fired) begin
         sh_auto_fired = 1'b1;
         fired = sh_auto_act;
      end
      push_rsp(jsas_pkg::KIND_FINISH, 16'd0, jsas_pkg::PH_IDLE, jsas_pkg::STAT_OK, fired);
   endtask

   // Admit eligible idle jobs, lowest id first, then run the finish check
   task automatic admit_jobs(input logic [47:0] now);
      int running, best, lim;
      running = 0;
      lim = (sh_limit > CAP) ? CAP : sh_limit;
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i] && sh_phase[i] == jsas_pkg::PH_RUNNING) running++;
      while (running < lim) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!sh_valid[i] || sh_phase[i] != jsas_pkg::PH_IDLE) continue;
            if (sh_start[i] != 0 && sh_start[i] > now) continue;
            if (best < 0 || sh_ident[i] < sh_ident[best]) best = i;
         end
         if (best < 0) break;
         sh_phase[best] = jsas_pkg::PH_RUNNING;
         push_rsp(jsas_pkg::KIND_START, sh_ident[best], jsas_pkg::PH_RUNNING,
                  jsas_pkg::STAT_OK, 2'd0);
         running++;
      end
      finish_check();
   endtask

   task automatic predict_request(input jsas_pkg::req_type q);
      int s, base;
      logic [2:0] prior, need;
      base = expected_rsps.size();
      s = -1;
      if (q.action == jsas_pkg::ACT_ADD) begin
         for (int i = 0; i < SLOTS; i++)
            if (!sh_valid[i]) begin s = i; break; end
         if (s < 0) push_rsp(jsas_pkg::KIND_ACK, 16'd0, jsas_pkg::PH_IDLE,
                             jsas_pkg::STAT_FULL, 2'd0);
         else begin
            sh_valid[s] = 1'b1;
            sh_ident[s] = sh_next_id;
            sh_phase[s] = q.start_paused ? jsas_pkg::PH_PAUSED : jsas_pkg::PH_IDLE;
            sh_start[s] = q.start_at;
            sh_next_id++;
            sh_fin_reported = 1'b0;
            sh_auto_fired = 1'b0;
            push_rsp(jsas_pkg::KIND_ACK, sh_ident[s], sh_phase[s], jsas_pkg::STAT_OK, 2'd0);
            if (!q.start_paused) admit_jobs(q.now_ms);
         end
      end else if (q.action == jsas_pkg::ACT_TICK) begin
         push_rsp(jsas_pkg::KIND_ACK, 16'd0, jsas_pkg::PH_IDLE, jsas_pkg::STAT_OK, 2'd0);
         admit_jobs(q.now_ms);
      end else if (q.action > jsas_pkg::ACT_TICK) begin
         push_rsp(jsas_pkg::KIND_ACK, 16'd0, jsas_pkg::PH_IDLE, jsas_pkg::STAT_NF, 2'd0);
      end else begin
         s = lookup_slot(q.job_id);
         if (q.action == jsas_pkg::ACT_REMOVE) begin
            if (s < 0) push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_IDLE,
                                jsas_pkg::STAT_NF, 2'd0);
            else begin
               prior = sh_phase[s];
               push_rsp(jsas_pkg::KIND_ACK, q.job_id, prior, jsas_pkg::STAT_OK, 2'd0);
               if (prior == jsas_pkg::PH_RUNNING)
                  push_rsp(jsas_pkg::KIND_CANCEL, q.job_id, jsas_pkg::PH_RUNNING,
                           jsas_pkg::STAT_OK, 2'd0);
               sh_valid[s] = 1'b0;
            end
            admit_jobs(q.now_ms);
         end else if (s < 0) begin
            push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_IDLE, jsas_pkg::STAT_NF, 2'd0);
         end else if (q.action == jsas_pkg::ACT_PAUSE) begin
            if (sh_phase[s] == jsas_pkg::PH_RUNNING) begin
               // running job stays running until the cancelled action
               push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_RUNNING,
                        jsas_pkg::STAT_OK, 2'd0);
               push_rsp(jsas_pkg::KIND_CANCEL, q.job_id, jsas_pkg::PH_RUNNING,
                        jsas_pkg::STAT_OK, 2'd0);
            end else if (sh_phase[s] == jsas_pkg::PH_IDLE) begin
               sh_phase[s] = jsas_pkg::PH_PAUSED;
               push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_PAUSED,
                        jsas_pkg::STAT_OK, 2'd0);
               finish_check();
            end else push_rsp(jsas_pkg::KIND_ACK, q.job_id, sh_phase[s],
                              jsas_pkg::STAT_NF, 2'd0);
         end else if (q.action == jsas_pkg::ACT_RESUME || q.action == jsas_pkg::ACT_RETRY) begin
            need = (q.action == jsas_pkg::ACT_RESUME) ? jsas_pkg::PH_PAUSED
                                                      : jsas_pkg::PH_FAILED;
            if (sh_phase[s] == need) begin
               sh_phase[s] = jsas_pkg::PH_IDLE;
               sh_fin_reported = 1'b0;
               push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_IDLE,
                        jsas_pkg::STAT_OK, 2'd0);
               admit_jobs(q.now_ms);
            end else push_rsp(jsas_pkg::KIND_ACK, q.job_id, sh_phase[s],
                              jsas_pkg::STAT_NF, 2'd0);
         end else if (q.action == jsas_pkg::ACT_FINISHED || q.action == jsas_pkg::ACT_ERROR) begin
            sh_phase[s] = (q.action == jsas_pkg::ACT_FINISHED) ? jsas_pkg::PH_DONE
                                                               : jsas_pkg::PH_FAILED;
            push_rsp(jsas_pkg::KIND_ACK, q.job_id, sh_phase[s], jsas_pkg::STAT_OK, 2'd0);
            admit_jobs(q.now_ms);
         end else begin
            if (sh_phase[s] == jsas_pkg::PH_RUNNING) begin
               sh_phase[s] = jsas_pkg::PH_PAUSED;
               push_rsp(jsas_pkg::KIND_ACK, q.job_id, jsas_pkg::PH_PAUSED,
                        jsas_pkg::STAT_OK, 2'd0);
            end else push_rsp(jsas_pkg::KIND_ACK, q.job_id, sh_phase[s],
                              jsas_pkg::STAT_NF, 2'd0);
            admit_jobs(q.now_ms);
         end
      end
      if (expected_rsps.size() > base)
         expected_rsps[expected_rsps.size() - 1].last = 1'b1;
   endtask

   // Send one request after a random gap; prediction at acceptance.
   // Valid stays high when the next request follows with no gap.
   task automatic send_request(input jsas_pkg::req_type q);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      predict_request(q);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [2:0] val);
      logic [2:0] v;
      req_valid <= 1'b0;
      // idle: drain results, then allow the trailing scan to finish
      wait (expected_rsps.size() == 0);
      repeat (160) @(posedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == jsas_pkg::CSR_MAX_CONC) begin
         v = val;
         if (v < jsas_pkg::CONC_FLOOR) v = jsas_pkg::CONC_FLOOR;
         if (v > jsas_pkg::CONC_CEIL) v = jsas_pkg::CONC_CEIL;
         sh_limit = v;
      end else sh_auto_act = val[1:0];
   endtask

   function automatic jsas_pkg::req_type make_req(input logic [3:0] act,
                                                  input logic [15:0] id,
                                                  input logic sp, input logic [47:0] at,
                                                  input logic [47:0] now);
      jsas_pkg::req_type q;
      q.action = act; q.job_id = id; q.start_paused = sp;
      q.start_at = at; q.now_ms = now;
      return q;
   endfunction

   // Pick a live id most of the time so sequences go deep
   function automatic logic [15:0] pick_id();
      int s;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      for (int k = 0; k < 8; k++) begin
         s = $urandom_range(0, SLOTS - 1);
         if (sh_valid[s]) return sh_ident[s];
      end
      return sh_next_id - 16'd1;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Result checker: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result kind=%0d ref=%0d", rsp_data.kind, rsp_data.job_ref);
               fail_count++;
            end else begin
               jsas_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.kind !== e.kind) begin
                  $error("kind: expected %0d actual %0d", e.kind, rsp_data.kind);
                  fail_count++;
               end
               if (rsp_data.job_ref !== e.job_ref) begin
                  $error("job_ref: expected %0d actual %0d", e.job_ref, rsp_data.job_ref);
                  fail_count++;
               end
               if (rsp_data.job_state !== e.job_state) begin
                  $error("job_state: expected %0d actual %0d", e.job_state,
                         rsp_data.job_state);
                  fail_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.fired_action !== e.fired_action) begin
                  $error("fired_action: expected %0d actual %0d", e.fired_action,
                         rsp_data.fired_action);
                  fail_count++;
               end
               if (rsp_data.last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver stall: once enabled, a random hold-off after each accepted result
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_stall_rand && rsp_valid && !rsp_stall) begin
            hold = $urandom_range(0, 6);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Directed: empty-table finish, full table, every action and a bad code
   task automatic test_directed();
      send_request(make_req(jsas_pkg::ACT_TICK, 16'd0, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_ADD, 16'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 48'd5));
      send_request(make_req(jsas_pkg::ACT_ADD, 16'hFFFF, 1'b1, 48'd0, 48'hFFFF_FFFF_FFFF));
      for (int i = 0; i < 15; i++)
         send_request(make_req(jsas_pkg::ACT_ADD, 16'd0, 1'b0, 48'd0, 48'd0));
      // table full
      send_request(make_req(jsas_pkg::ACT_ADD, 16'd0, 1'b0, 48'd0, 48'd0));
      // running
      send_request(make_req(jsas_pkg::ACT_PAUSE, 16'd2, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_CANCELLED, 16'd2, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_RESUME, 16'd1, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_ERROR, 16'd3, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_RETRY, 16'd3, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_FINISHED, 16'd4, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_REMOVE, 16'd5, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_REMOVE, 16'hFFFF, 1'b0, 48'd0, 48'd0));
      send_request(make_req(4'd15, 16'd0, 1'b0, 48'd0, 48'd0));
      send_request(make_req(jsas_pkg::ACT_TICK, 16'd0, 1'b0, 48'd0, 48'hFFFF_FFFF_FFFF));
   endtask

   // Random: mostly lifecycle actions on live jobs, some noise
   task automatic test_random(input int count);
      jsas_pkg::req_type q;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         q = make_req(jsas_pkg::ACT_TICK, pick_id(), 1'($urandom), rand48(), rand48());
         if (pick < 25) begin
            q.action = jsas_pkg::ACT_ADD;
            if ($urandom_range(0, 1)) q.start_at = 48'd0;
            else if ($urandom_range(0, 1)) q.start_at = 48'($urandom_range(0, 2000));
            q.now_ms = 48'($urandom_range(0, 3000));
         end else if (pick < 92) begin
            q.action = 4'($urandom_range(1, 8));
            if ($urandom_range(0, 2) != 0) q.now_ms = 48'($urandom_range(0, 3000));
         end else q.action = 4'($urandom_range(9, 15));
         send_request(q);
      end
   endtask

   task automatic test_config_sweep();
      csr_write(jsas_pkg::CSR_MAX_CONC, 3'd0);   // stored as the floor
      csr_write(jsas_pkg::CSR_AUTO_ACT, 3'd3);
      test_random(30);
      csr_write(jsas_pkg::CSR_MAX_CONC, 3'd7);   // stored as the ceiling
      csr_write(jsas_pkg::CSR_AUTO_ACT, 3'd1);
      test_random(30);
      csr_write(jsas_pkg::CSR_MAX_CONC, 3'd5);
      csr_write(jsas_pkg::CSR_AUTO_ACT, 3'd0);
      test_random(25);
      csr_write(jsas_pkg::CSR_MAX_CONC, 3'd2);
      csr_write(jsas_pkg::CSR_AUTO_ACT, 3'd2);
      test_random(30);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 1'b0; sh_ident[i] = '0; sh_phase[i] = '0; sh_start[i] = '0;
      end
      sh_next_id = '0; sh_fin_reported = 1'b0; sh_auto_fired = 1'b0;
      sh_limit = jsas_pkg::CONC_RESET; sh_auto_act = 2'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      rsp_stall_rand = 1'b1;
      test_random(25);
      test_config_sweep();
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/jsas_pkg.sv
rtl/jsas_ram.sv
rtl/jsas_dp.sv
rtl/jsas_ctrl.sv
rtl/job_slot_admission_scheduler_top.sv
sim/job_slot_admission_scheduler_top_test.sv
